[design/lbps_pkg.sv]
// lbps_pkg: shared types, codes and timing constants for the LED, beep and
// button press sequencer. No dependencies; compiled first.

package lbps_pkg;

  // wrapping millisecond time base
  localparam int unsigned TIME_BITS = 32;
  typedef logic [TIME_BITS-1:0] time_t;

  // register and duration width
  localparam int unsigned MS_BITS = 16;
  typedef logic [MS_BITS-1:0] ms_t;

  // input beat fields
  localparam int unsigned MODE_BITS = 3;
  localparam int unsigned ARG_BITS  = 8;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_TICK        = 3'd0,
    MODE_SET_LED     = 3'd1,
    MODE_BEEP        = 3'd2,
    MODE_SHORT_PRESS = 3'd3,
    MODE_LONG_PRESS  = 3'd4,
    MODE_ABORT       = 3'd5
  } mode_e;

  // configuration register indexes
  localparam int unsigned CFG_IDX_BITS = 3;
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_BEEP_ON      = 3'd0,
    CFG_BEEP_GAP     = 3'd1,
    CFG_BEEP_END_GAP = 3'd2,
    CFG_SHORT_PRESS  = 3'd3,
    CFG_LONG_PRESS   = 3'd4,
    CFG_PRESS_GAP    = 3'd5
  } cfg_idx_e;

  // configuration reset values
  localparam ms_t RST_BEEP_ON      = 16'd100;
  localparam ms_t RST_BEEP_GAP     = 16'd100;
  localparam ms_t RST_BEEP_END_GAP = 16'd300;
  localparam ms_t RST_SHORT_PRESS  = 16'd200;
  localparam ms_t RST_LONG_PRESS   = 16'd2000;
  localparam ms_t RST_PRESS_GAP    = 16'd500;

  // pattern codes
  typedef logic [2:0] pat_t;
  localparam logic [ARG_BITS-1:0] PAT_MAX = 8'd5;
  localparam pat_t LED_OFF         = 3'd0;
  localparam pat_t LED_STEADY      = 3'd1;
  localparam pat_t LED_LONG_FLASH  = 3'd2;
  localparam pat_t LED_QUICK_FLASH = 3'd3;
  localparam pat_t LED_LOCKOUT     = 3'd4;
  localparam pat_t LED_ERROR       = 3'd5;
  localparam pat_t BEEP_SILENT     = 3'd0;
  localparam pat_t BEEP_ONCE       = 3'd1;
  localparam pat_t BEEP_TWICE      = 3'd2;
  localparam pat_t BEEP_THRICE     = 3'd3;
  localparam pat_t BEEP_ERR_FAST   = 3'd4;
  localparam pat_t BEEP_LOW_BATT   = 3'd5;

  // fixed LED and beep timings
  localparam ms_t LED_REFRESH_MS  = 16'd1000;
  localparam ms_t LED_FAST_ON_MS  = 16'd100;
  localparam ms_t LED_FAST_OFF_MS = 16'd150;
  localparam ms_t LED_SLOW_ON_MS  = 16'd300;
  localparam ms_t LED_SLOW_OFF_MS = 16'd700;
  localparam ms_t BEEP_FAST_ON_MS = 16'd50;

  // beep engine phase
  typedef enum logic [1:0] {
    PH_ON  = 2'd0,
    PH_OFF = 2'd1,
    PH_END = 2'd2
  } beep_phase_e;

  typedef logic [2:0] beep_cnt_t;

  typedef struct packed {
    ms_t beep_on;
    ms_t beep_gap;
    ms_t beep_end_gap;
    ms_t short_press;
    ms_t long_press;
    ms_t press_gap;
  } cfg_regs_t;

  typedef struct packed {
    logic led_on;
    logic buzzer_on;
    logic button_pressed;
    logic accepted;
    logic busy_res;
  } result_t;

  // number of beeps in each beep pattern
  function automatic beep_cnt_t beep_count(input pat_t pat);
    beep_cnt_t cnt;
    case (pat)
      BEEP_ONCE:     cnt = 3'd1;
      BEEP_TWICE:    cnt = 3'd2;
      BEEP_THRICE:   cnt = 3'd3;
      BEEP_ERR_FAST: cnt = 3'd4;
      BEEP_LOW_BATT: cnt = 3'd2;
      default:       cnt = 3'd0;
    endcase
    return cnt;
  endfunction

endpackage

[design/lbps_in_if.sv]
// lbps_in_if: valid/ready channel for input beats (mode and pattern argument).
// Depends on lbps_pkg.

interface lbps_in_if import lbps_pkg::*;;
  logic                valid;
  logic                ready;
  logic [MODE_BITS-1:0] mode;
  logic [ARG_BITS-1:0]  pattern_arg;

  modport source (output valid, output mode, output pattern_arg, input ready);
  modport sink   (input valid, input mode, input pattern_arg, output ready);
endinterface

[design/lbps_out_if.sv]
// lbps_out_if: valid/ready channel for result beats (output levels and status).
// No package dependency.

interface lbps_out_if;
  logic valid;
  logic ready;
  logic led_on;
  logic buzzer_on;
  logic button_pressed;
  logic accepted;
  logic busy_res;

  modport source (output valid, output led_on, output buzzer_on, output button_pressed,
                  output accepted, output busy_res, input ready);
  modport sink   (input valid, input led_on, input buzzer_on, input button_pressed,
                  input accepted, input busy_res, output ready);
endinterface

[design/led_beep_press_sequencer.sv]
// led_beep_press_sequencer: top level with input register, result register and
// configuration registers. Depends on lbps_pkg, lbps_in_if, lbps_out_if, lbps_engine.
//
// Usage:
//   in_ch carries one beat per item: mode (tick, set LED, beep, short press,
//   long press, abort) and pattern_arg. out_ch returns exactly one result beat
//   per input beat: LED, buzzer and button levels after the engines have
//   stepped, plus accepted and busy_res. A refused press comes back with
//   accepted low; the sender holds the action and retries it later.
//   A beat waits in the input register while the engines step on it; its
//   result is written into the result register as the beat leaves the input
//   register, and out_ch.valid is driven from that register.
//   Throughput is one beat per cycle while out_ch takes results; the combinational
//   engine step sets that rate, as each beat needs the state left by the one before.
//   When out_ch stalls, one result waits in the result register and one
//   more beat is taken into the input register before in_ch.ready drops.
//   Reset (rst_n low, synchronous) clears time, all engines and both stages
//   and loads the default durations. Configuration writes (cfg_we, cfg_index,
//   cfg_wdata) take effect at once and are meant for idle periods.

module led_beep_press_sequencer import lbps_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  lbps_in_if.sink                 in_ch,
  lbps_out_if.source              out_ch,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  ms_t                     cfg_wdata
);

  cfg_regs_t            cfg_r;
  logic                 s0_valid_r;
  logic [MODE_BITS-1:0] s0_mode_r;
  logic [ARG_BITS-1:0]  s0_arg_r;
  logic                 out_valid_r;
  result_t              out_res_r;
  result_t              step_res;
  logic                 s0_adv;

  // stage handshake
  assign s0_adv       = s0_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s0_valid_r || s0_adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.beep_on      <= RST_BEEP_ON;
      cfg_r.beep_gap     <= RST_BEEP_GAP;
      cfg_r.beep_end_gap <= RST_BEEP_END_GAP;
      cfg_r.short_press  <= RST_SHORT_PRESS;
      cfg_r.long_press   <= RST_LONG_PRESS;
      cfg_r.press_gap    <= RST_PRESS_GAP;
    end else if (cfg_we) begin
      case (cfg_idx_e'(cfg_index))
        CFG_BEEP_ON:      cfg_r.beep_on      <= cfg_wdata;
        CFG_BEEP_GAP:     cfg_r.beep_gap     <= cfg_wdata;
        CFG_BEEP_END_GAP: cfg_r.beep_end_gap <= cfg_wdata;
        CFG_SHORT_PRESS:  cfg_r.short_press  <= cfg_wdata;
        CFG_LONG_PRESS:   cfg_r.long_press   <= cfg_wdata;
        CFG_PRESS_GAP:    cfg_r.press_gap    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s0_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s0_mode_r <= in_ch.mode;
      s0_arg_r  <= in_ch.pattern_arg;
    end
  end

  // engines step as the beat leaves the input register
  lbps_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (s0_adv),
    .mode        (s0_mode_r),
    .pattern_arg (s0_arg_r),
    .cfg         (cfg_r),
    .res         (step_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s0_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_adv) begin
      out_res_r <= step_res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.led_on         = out_res_r.led_on;
  assign out_ch.buzzer_on      = out_res_r.buzzer_on;
  assign out_ch.button_pressed = out_res_r.button_pressed;
  assign out_ch.accepted       = out_res_r.accepted;
  assign out_ch.busy_res       = out_res_r.busy_res;

endmodule

[design/lbps_engine.sv]
// lbps_engine: time base plus LED, beep and press engines; one full step per beat.
// Depends on lbps_pkg.

module lbps_engine import lbps_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [MODE_BITS-1:0] mode,
  input  logic [ARG_BITS-1:0]  pattern_arg,
  input  cfg_regs_t            cfg,
  output result_t              res
);

  // engine state
  time_t       time_now_r, time_now_nxt;
  pat_t        led_pattern_r, led_pattern_nxt;
  logic        led_level_r, led_level_nxt;
  time_t       led_deadline_r, led_deadline_nxt;
  logic        beep_running_r, beep_running_nxt;
  pat_t        beep_kind_r, beep_kind_nxt;
  beep_cnt_t   beeps_left_r, beeps_left_nxt;
  beep_phase_e beep_phase_r, beep_phase_nxt;
  time_t       beep_deadline_r, beep_deadline_nxt;
  logic        buzzer_level_r, buzzer_level_nxt;
  logic        press_running_r, press_running_nxt;
  logic        press_held_r, press_held_nxt;
  time_t       press_deadline_r, press_deadline_nxt;

  // state after the action, before the engines step
  pat_t        led_pat_a;
  logic        led_lvl_a;
  time_t       led_dl_a;
  logic        beep_run_a;
  pat_t        beep_kind_a;
  beep_cnt_t   beeps_left_a;
  beep_phase_e beep_ph_a;
  time_t       beep_dl_a;
  logic        buzzer_a;
  logic        press_run_a;
  logic        press_held_a;
  time_t       press_dl_a;
  logic        ok;
  pat_t        arg_pat;

  logic        led_due, beep_due, press_due;
  time_t       led_diff, beep_diff, press_diff;

  assign arg_pat = (pattern_arg > PAT_MAX) ? LED_OFF : pattern_arg[2:0];

  // action phase
  always_comb begin
    time_now_nxt = time_now_r;
    led_pat_a    = led_pattern_r;
    led_lvl_a    = led_level_r;
    led_dl_a     = led_deadline_r;
    beep_run_a   = beep_running_r;
    beep_kind_a  = beep_kind_r;
    beeps_left_a = beeps_left_r;
    beep_ph_a    = beep_phase_r;
    beep_dl_a    = beep_deadline_r;
    buzzer_a     = buzzer_level_r;
    press_run_a  = press_running_r;
    press_held_a = press_held_r;
    press_dl_a   = press_deadline_r;
    ok           = 1'b1;
    case (mode_e'(mode))
      MODE_TICK: begin
        time_now_nxt = time_now_r + time_t'(1);
      end
      MODE_SET_LED: begin
        led_pat_a = arg_pat;
        led_dl_a  = time_now_r;
      end
      MODE_BEEP: begin
        beep_kind_a  = arg_pat;
        beep_ph_a    = PH_ON;
        beeps_left_a = beep_count(arg_pat);
        beep_run_a   = (arg_pat != BEEP_SILENT);
        beep_dl_a    = time_now_r;
        if (arg_pat == BEEP_SILENT) begin
          buzzer_a = 1'b0;
        end
      end
      MODE_SHORT_PRESS, MODE_LONG_PRESS: begin
        if (press_running_r) begin
          ok = 1'b0;
        end else begin
          press_run_a  = 1'b1;
          press_held_a = 1'b1;
          press_dl_a   = time_now_r + time_t'((mode_e'(mode) == MODE_SHORT_PRESS) ?
                                              cfg.short_press : cfg.long_press);
        end
      end
      MODE_ABORT: begin
        led_pat_a    = LED_OFF;
        led_lvl_a    = 1'b0;
        led_dl_a     = '0;
        beep_run_a   = 1'b0;
        beep_kind_a  = BEEP_SILENT;
        beeps_left_a = '0;
        beep_ph_a    = PH_ON;
        beep_dl_a    = '0;
        buzzer_a     = 1'b0;
        press_run_a  = 1'b0;
        press_held_a = 1'b0;
        press_dl_a   = '0;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // wrap-safe deadline checks against the updated time
  assign led_diff   = time_now_nxt - led_dl_a;
  assign beep_diff  = time_now_nxt - beep_dl_a;
  assign press_diff = time_now_nxt - press_dl_a;
  assign led_due    = !led_diff[TIME_BITS-1];
  assign beep_due   = !beep_diff[TIME_BITS-1];
  assign press_due  = !press_diff[TIME_BITS-1];

  // led engine step
  always_comb begin
    led_pattern_nxt  = led_pat_a;
    led_level_nxt    = led_lvl_a;
    led_deadline_nxt = led_dl_a;
    if (led_due) begin
      if (led_pat_a == LED_OFF || led_pat_a == LED_STEADY || led_pat_a > PAT_MAX[2:0]) begin
        if (led_pat_a > PAT_MAX[2:0]) begin
          led_pattern_nxt = LED_OFF;
        end
        led_level_nxt    = (led_pat_a == LED_STEADY);
        led_deadline_nxt = time_now_nxt + time_t'(LED_REFRESH_MS);
      end else if (!led_lvl_a) begin
        led_level_nxt    = 1'b1;
        led_deadline_nxt = time_now_nxt + time_t'((led_pat_a == LED_QUICK_FLASH) ?
                                                  LED_FAST_ON_MS : LED_SLOW_ON_MS);
      end else begin
        led_level_nxt    = 1'b0;
        led_deadline_nxt = time_now_nxt + time_t'((led_pat_a == LED_QUICK_FLASH) ?
                                                  LED_FAST_OFF_MS : LED_SLOW_OFF_MS);
      end
    end
  end

  // beep engine step
  always_comb begin
    beep_running_nxt  = beep_run_a;
    beep_kind_nxt     = beep_kind_a;
    beeps_left_nxt    = beeps_left_a;
    beep_phase_nxt    = beep_ph_a;
    beep_deadline_nxt = beep_dl_a;
    buzzer_level_nxt  = buzzer_a;
    if (beep_run_a && beep_due) begin
      if (beeps_left_a == '0) begin
        buzzer_level_nxt = 1'b0;
        beep_running_nxt = 1'b0;
      end else begin
        case (beep_ph_a)
          PH_ON: begin
            buzzer_level_nxt  = 1'b1;
            beep_deadline_nxt = time_now_nxt + time_t'((beep_kind_a == BEEP_ERR_FAST) ?
                                                       BEEP_FAST_ON_MS : cfg.beep_on);
            beep_phase_nxt    = PH_OFF;
          end
          PH_OFF: begin
            buzzer_level_nxt = 1'b0;
            beeps_left_nxt   = beeps_left_a - beep_cnt_t'(1);
            if (beeps_left_a == beep_cnt_t'(1)) begin
              beep_deadline_nxt = time_now_nxt + time_t'(cfg.beep_end_gap);
              beep_phase_nxt    = PH_END;
            end else begin
              beep_deadline_nxt = time_now_nxt + time_t'(cfg.beep_gap);
              beep_phase_nxt    = PH_ON;
            end
          end
          default: begin
            beep_running_nxt = 1'b0;
          end
        endcase
      end
    end
  end

  // press engine step
  always_comb begin
    press_running_nxt  = press_run_a;
    press_held_nxt     = press_held_a;
    press_deadline_nxt = press_dl_a;
    if (press_run_a && press_due) begin
      if (press_held_a) begin
        press_held_nxt     = 1'b0;
        press_deadline_nxt = time_now_nxt + time_t'(cfg.press_gap);
      end else begin
        press_running_nxt = 1'b0;
      end
    end
  end

  // result fields, sampled after the step
  always_comb begin
    res.led_on         = led_level_nxt;
    res.buzzer_on      = buzzer_level_nxt;
    res.button_pressed = press_held_nxt;
    res.accepted       = ok;
    res.busy_res       = beep_running_nxt || press_running_nxt;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_now_r       <= '0;
      led_pattern_r    <= LED_OFF;
      led_level_r      <= 1'b0;
      led_deadline_r   <= '0;
      beep_running_r   <= 1'b0;
      beep_kind_r      <= BEEP_SILENT;
      beeps_left_r     <= '0;
      beep_phase_r     <= PH_ON;
      beep_deadline_r  <= '0;
      buzzer_level_r   <= 1'b0;
      press_running_r  <= 1'b0;
      press_held_r     <= 1'b0;
      press_deadline_r <= '0;
    end else if (step) begin
      time_now_r       <= time_now_nxt;
      led_pattern_r    <= led_pattern_nxt;
      led_level_r      <= led_level_nxt;
      led_deadline_r   <= led_deadline_nxt;
      beep_running_r   <= beep_running_nxt;
      beep_kind_r      <= beep_kind_nxt;
      beeps_left_r     <= beeps_left_nxt;
      beep_phase_r     <= beep_phase_nxt;
      beep_deadline_r  <= beep_deadline_nxt;
      buzzer_level_r   <= buzzer_level_nxt;
      press_running_r  <= press_running_nxt;
      press_held_r     <= press_held_nxt;
      press_deadline_r <= press_deadline_nxt;
    end
  end

  // a held button always belongs to a running press
  a_held_in_press: assert property (@(posedge clk) disable iff (!rst_n)
    press_held_r |-> press_running_r)
    else $error("button held with no press running");

  // the end gap is only reached once every beep has played
  a_end_gap_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (beep_running_r && beep_phase_r == PH_END) |-> beeps_left_r == '0)
    else $error("beep end gap with beeps still left");

  // a finished or stopped beep leaves the buzzer silent
  a_beep_stop_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(beep_running_r) |-> !buzzer_level_r)
    else $error("buzzer left on after beep stopped");

  // time only moves with a beat
  a_time_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(time_now_r))
    else $error("time base moved without a beat");

endmodule
